/* src/gbsr_pkg.sv */
// ----------------------------------------------------------------------------
// gbsr_pkg
// Types, button bit masks, remap tables and helper functions shared by the
// pad sample remapper pipeline.
// ----------------------------------------------------------------------------
package gbsr_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ANALOG = 2'd0;
  localparam logic [1:0] CFG_BUTTON = 2'd1;

  // Button bits.
  localparam logic [31:0] B_A      = 32'h0000_0001;
  localparam logic [31:0] B_B      = 32'h0000_0002;
  localparam logic [31:0] B_X      = 32'h0000_0004;
  localparam logic [31:0] B_Y      = 32'h0000_0008;
  localparam logic [31:0] B_SL     = 32'h0000_0010;
  localparam logic [31:0] B_SR     = 32'h0000_0020;
  localparam logic [31:0] B_L      = 32'h0000_0040;
  localparam logic [31:0] B_R      = 32'h0000_0080;
  localparam logic [31:0] B_ZL     = 32'h0000_0100;
  localparam logic [31:0] B_ZR     = 32'h0000_0200;
  localparam logic [31:0] B_PLUS   = 32'h0000_0400;
  localparam logic [31:0] B_MINUS  = 32'h0000_0800;
  localparam logic [31:0] B_LEFT   = 32'h0000_1000;
  localparam logic [31:0] B_UP     = 32'h0000_2000;
  localparam logic [31:0] B_RIGHT  = 32'h0000_4000;
  localparam logic [31:0] B_DOWN   = 32'h0000_8000;
  localparam logic [31:0] B_LLEFT  = 32'h0001_0000;
  localparam logic [31:0] B_LUP    = 32'h0002_0000;
  localparam logic [31:0] B_LRIGHT = 32'h0004_0000;
  localparam logic [31:0] B_LDOWN  = 32'h0008_0000;
  localparam logic [31:0] B_RLEFT  = 32'h0010_0000;
  localparam logic [31:0] B_RUP    = 32'h0020_0000;
  localparam logic [31:0] B_RRIGHT = 32'h0040_0000;
  localparam logic [31:0] B_RDOWN  = 32'h0080_0000;
  localparam logic [31:0] B_ANYSL  = 32'h0500_0000;
  localparam logic [31:0] B_ANYSR  = 32'h0A00_0000;
  localparam logic [31:0] B_NONE   = 32'h0000_0000;

  localparam logic [31:0] STICK_DIRS = B_LLEFT | B_LUP | B_LRIGHT | B_LDOWN |
                                       B_RLEFT | B_RUP | B_RRIGHT | B_RDOWN;
  localparam logic [31:0] SHOULDERS  = B_L | B_R | B_ZL | B_ZR;

  localparam logic signed [15:0] STICK_MIN = 16'sh8000;
  localparam logic signed [15:0] STICK_MAX = 16'sh7FFF;

  localparam int unsigned MAP_LEN = 8;

  typedef struct packed {
    logic [31:0] src;
    logic [31:0] dst;
  } pair_t;

  typedef pair_t [MAP_LEN-1:0] map_t;

  // Unused entries have an empty source, so they never fire.
  localparam pair_t P_NONE = '{src: B_NONE, dst: B_NONE};

  localparam map_t ORIENT_MAP = '{
    '{B_LDOWN, B_LRIGHT}, '{B_LUP, B_LLEFT}, '{B_LRIGHT, B_LUP}, '{B_LLEFT, B_LDOWN},
    '{B_RDOWN, B_RLEFT}, '{B_RUP, B_RRIGHT}, '{B_RRIGHT, B_RDOWN}, '{B_RLEFT, B_RUP}};
  localparam map_t R_TO_L_MAP = '{
    P_NONE, P_NONE, P_NONE, '{B_SR, B_SL},
    '{B_RDOWN, B_LDOWN}, '{B_RUP, B_LUP}, '{B_RRIGHT, B_LRIGHT}, '{B_RLEFT, B_LLEFT}};
  localparam map_t L_TO_R_MAP = '{
    P_NONE, P_NONE, P_NONE, '{B_SL, B_SR},
    '{B_LDOWN, B_RDOWN}, '{B_LUP, B_RUP}, '{B_LRIGHT, B_RRIGHT}, '{B_LLEFT, B_RLEFT}};
  localparam map_t TO_DPAD_MAP = '{
    '{B_LDOWN, B_DOWN}, '{B_LUP, B_UP}, '{B_LRIGHT, B_RIGHT}, '{B_LLEFT, B_LEFT},
    '{B_RDOWN, B_DOWN}, '{B_RUP, B_UP}, '{B_RRIGHT, B_RIGHT}, '{B_RLEFT, B_LEFT}};
  localparam map_t DPAD_FACE_MAP = '{
    P_NONE, P_NONE, P_NONE, P_NONE,
    '{B_LEFT, B_Y}, '{B_UP, B_X}, '{B_DOWN, B_B}, '{B_RIGHT, B_A}};
  localparam map_t FACE_DPAD_MAP = '{
    P_NONE, P_NONE, P_NONE, P_NONE,
    '{B_Y, B_LEFT}, '{B_X, B_UP}, '{B_B, B_DOWN}, '{B_A, B_RIGHT}};
  localparam map_t ROT_RIGHT_MAP = '{
    '{B_LEFT, B_UP}, '{B_DOWN, B_LEFT}, '{B_RIGHT, B_DOWN}, '{B_UP, B_RIGHT},
    '{B_B, B_Y}, '{B_Y, B_X}, '{B_A, B_B}, '{B_X, B_A}};
  localparam map_t ROT_LEFT_MAP = '{
    '{B_LEFT, B_DOWN}, '{B_DOWN, B_RIGHT}, '{B_RIGHT, B_UP}, '{B_UP, B_LEFT},
    '{B_Y, B_B}, '{B_X, B_Y}, '{B_B, B_A}, '{B_A, B_X}};
  localparam map_t SLSR_LR_MAP = '{
    P_NONE, P_NONE, P_NONE, P_NONE, P_NONE, P_NONE,
    '{B_ANYSR, B_R}, '{B_ANYSL, B_L}};
  localparam map_t SLSR_Z_MAP = '{
    P_NONE, P_NONE, P_NONE, P_NONE, P_NONE, P_NONE,
    '{B_ANYSR, B_ZR}, '{B_ANYSL, B_ZL}};
  localparam map_t MINUS_PLUS_MAP = '{
    P_NONE, P_NONE, P_NONE, P_NONE, P_NONE, P_NONE, P_NONE, '{B_MINUS, B_PLUS}};
  localparam map_t PLUS_MINUS_MAP = '{
    P_NONE, P_NONE, P_NONE, P_NONE, P_NONE, P_NONE, P_NONE, '{B_PLUS, B_MINUS}};

  // Live configuration, as seen by the stages.
  typedef struct packed {
    logic [4:0] analog;
    logic [8:0] button;
  } cfg_t;

  // One pad sample travelling through the pipeline.
  typedef struct packed {
    logic [31:0]        now;
    logic [31:0]        bef;
    logic signed [15:0] lx;
    logic signed [15:0] ly;
    logic signed [15:0] rx;
    logic signed [15:0] ry;
  } sample_t;

  // Squared components of both sticks.
  typedef struct packed {
    logic [31:0] lxx;
    logic [31:0] lyy;
    logic [31:0] rxx;
    logic [31:0] ryy;
  } squares_t;

  // Every entry whose source touches the input clears its source bits and
  // sets its target, all against the same input word.
  function automatic logic [31:0] remap(input logic [31:0] v, input map_t m);
    logic [31:0] rem;
    logic [31:0] put;
    rem = '0;
    put = '0;
    for (int i = 0; i < MAP_LEN; i++) begin
      if ((v & m[i].src) != '0) begin
        rem = rem | m[i].src;
        put = put | m[i].dst;
      end
    end
    return (v & ~rem) | put;
  endfunction

  function automatic logic signed [15:0] sat_neg(input logic signed [15:0] v);
    return (v == STICK_MIN) ? STICK_MAX : -v;
  endfunction

endpackage

/* src/gbsr_btn.sv */
// ----------------------------------------------------------------------------
// gbsr_btn
// First pipeline stage: all button options, then the axis orientation of
// both sticks and of their direction bits.
// ----------------------------------------------------------------------------
module gbsr_btn (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  gbsr_pkg::cfg_t   cfg_i,
  input  logic             valid_i,
  output logic             ready_o,
  input  gbsr_pkg::sample_t data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output gbsr_pkg::sample_t data_o
);

  logic              valid_q;
  gbsr_pkg::sample_t data_q, data_d;

  function automatic logic [31:0] buttons(input logic [31:0] v, input logic [8:0] bo,
                                          input logic orient);
    logic [31:0] r;
    r = v;
    if (bo[0]) r = gbsr_pkg::remap(r, gbsr_pkg::DPAD_FACE_MAP);
    if (bo[1]) r = gbsr_pkg::remap(r, gbsr_pkg::FACE_DPAD_MAP);
    if (bo[2]) begin
      r = gbsr_pkg::remap(r, gbsr_pkg::ROT_RIGHT_MAP);
    end else if (bo[3]) begin
      r = gbsr_pkg::remap(r, gbsr_pkg::ROT_LEFT_MAP);
    end
    if (bo[4]) r = r & ~gbsr_pkg::SHOULDERS;
    if (bo[5]) r = gbsr_pkg::remap(r, gbsr_pkg::SLSR_LR_MAP);
    if (bo[6]) r = gbsr_pkg::remap(r, gbsr_pkg::SLSR_Z_MAP);
    if (bo[7]) r = gbsr_pkg::remap(r, gbsr_pkg::MINUS_PLUS_MAP);
    if (bo[8]) r = gbsr_pkg::remap(r, gbsr_pkg::PLUS_MINUS_MAP);
    if (orient) r = gbsr_pkg::remap(r, gbsr_pkg::ORIENT_MAP);
    return r;
  endfunction

  always_comb begin
    data_d     = data_i;
    data_d.now = buttons(data_i.now, cfg_i.button, cfg_i.analog[0]);
    data_d.bef = buttons(data_i.bef, cfg_i.button, cfg_i.analog[0]);
    // Left stick turns to (-y, x), right stick to (y, -x).
    if (cfg_i.analog[0]) begin
      data_d.lx = gbsr_pkg::sat_neg(data_i.ly);
      data_d.ly = data_i.lx;
      data_d.rx = data_i.ry;
      data_d.ry = gbsr_pkg::sat_neg(data_i.rx);
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* src/gbsr_sq.sv */
// ----------------------------------------------------------------------------
// gbsr_sq
// Second pipeline stage: squares each stick component for the length
// comparison; the sample itself rides along unchanged.
// ----------------------------------------------------------------------------
module gbsr_sq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  gbsr_pkg::sample_t  data_i,
  output logic               valid_o,
  input  logic               ready_i,
  output gbsr_pkg::sample_t  data_o,
  output gbsr_pkg::squares_t sq_o
);

  logic               valid_q;
  gbsr_pkg::sample_t  data_q;
  gbsr_pkg::squares_t sq_q, sq_d;

  always_comb begin
    sq_d.lxx = 32'(data_i.lx * data_i.lx);
    sq_d.lyy = 32'(data_i.ly * data_i.ly);
    sq_d.rxx = 32'(data_i.rx * data_i.rx);
    sq_d.ryy = 32'(data_i.ry * data_i.ry);
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_i;
      sq_q   <= sq_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
  assign sq_o    = sq_q;

endmodule

/* src/gbsr_sel.sv */
// ----------------------------------------------------------------------------
// gbsr_sel
// Third pipeline stage: dominant stick selection, stick assignment with its
// button moves, stick directions to d-pad and stick clearing. Holds the
// output register.
// ----------------------------------------------------------------------------
module gbsr_sel (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gbsr_pkg::cfg_t     cfg_i,
  input  logic               valid_i,
  output logic               ready_o,
  input  gbsr_pkg::sample_t  data_i,
  input  gbsr_pkg::squares_t sq_i,
  output logic               valid_o,
  input  logic               ready_i,
  output gbsr_pkg::sample_t  data_o
);

  logic              valid_q;
  gbsr_pkg::sample_t data_q, data_d;
  logic [32:0]       len_l, len_r;
  logic              right_wins;
  logic signed [15:0] dx, dy;

  // Assigning to the left pulls the right stick's buttons across, and
  // assigning to the right pulls the left stick's buttons across.
  function automatic logic [31:0] analog_btn(input logic [31:0] v, input logic [4:0] ao);
    logic [31:0] r;
    r = v;
    if (ao[2:1] == 2'b01) begin
      r = gbsr_pkg::remap(r, gbsr_pkg::R_TO_L_MAP);
    end else if (ao[2:1] == 2'b10) begin
      r = gbsr_pkg::remap(r, gbsr_pkg::L_TO_R_MAP);
    end
    if (ao[3]) r = gbsr_pkg::remap(r, gbsr_pkg::TO_DPAD_MAP);
    if (ao[4]) r = r & ~gbsr_pkg::STICK_DIRS;
    return r;
  endfunction

  always_comb begin
    len_l      = {1'b0, sq_i.lxx} + {1'b0, sq_i.lyy};
    len_r      = {1'b0, sq_i.rxx} + {1'b0, sq_i.ryy};
    right_wins = len_l < len_r;
    dx         = right_wins ? data_i.rx : data_i.lx;
    dy         = right_wins ? data_i.ry : data_i.ly;

    data_d     = data_i;
    data_d.now = analog_btn(data_i.now, cfg_i.analog);
    data_d.bef = analog_btn(data_i.bef, cfg_i.analog);
    case (cfg_i.analog[2:1])
      2'b11: begin
        data_d.lx = dx;
        data_d.ly = dy;
        data_d.rx = dx;
        data_d.ry = dy;
      end
      2'b01: begin
        data_d.lx = dx;
        data_d.ly = dy;
        data_d.rx = '0;
        data_d.ry = '0;
      end
      2'b10: begin
        data_d.lx = '0;
        data_d.ly = '0;
        data_d.rx = dx;
        data_d.ry = dy;
      end
      default: begin
      end
    endcase
    if (cfg_i.analog[4]) begin
      data_d.lx = '0;
      data_d.ly = '0;
      data_d.rx = '0;
      data_d.ry = '0;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* src/gamepad_button_stick_remapper.sv */
// ----------------------------------------------------------------------------
// gamepad_button_stick_remapper
// Remaps one pad sample (two button vectors and two sticks) according to
// the button and analog option registers, in a three-stage pipeline.
// ----------------------------------------------------------------------------
//
//   Channel | Signals                         | Direction | Payload
//   --------+---------------------------------+-----------+---------------------------
//   in      | in_valid_i / in_ready_o         | into      | buttons, four stick axes
//   out     | out_valid_o / out_ready_i       | out of    | remapped buttons and axes
//   cfg     | cfg_valid_i / cfg_ready_o       | into      | register index, write data
//
// A sample is accepted in every cycle unless a full pipeline stalls on the
// output, and passes the three register stages (buttons, squares, selection)
// in order; throughput is one sample per cycle while the output is ready.
// Reset clears the valid bits and both option registers to zero.
// Each stage holds its sample while the one after it is full and stalled,
// and fills a bubble even while the output waits, so nothing is lost or
// repeated.
//
module gamepad_button_stick_remapper (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration write channel.
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [8:0]         cfg_data_i,
  // Input sample channel.
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [31:0]        buttons_now_i,
  input  logic [31:0]        buttons_before_i,
  input  logic signed [15:0] left_x_in_i,
  input  logic signed [15:0] left_y_in_i,
  input  logic signed [15:0] right_x_in_i,
  input  logic signed [15:0] right_y_in_i,
  // Result channel.
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [31:0]        buttons_now_out_o,
  output logic [31:0]        buttons_before_out_o,
  output logic signed [15:0] left_x_out_o,
  output logic signed [15:0] left_y_out_o,
  output logic signed [15:0] right_x_out_o,
  output logic signed [15:0] right_y_out_o
);

  // Option registers. The user must write them only while the pipeline is
  // empty; the block itself does not enforce this. The stages read them directly.
  logic [4:0] analog_q;
  logic [8:0] button_q;
  gbsr_pkg::cfg_t cfg;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      analog_q <= '0;
      button_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        gbsr_pkg::CFG_ANALOG: analog_q <= cfg_data_i[4:0];
        gbsr_pkg::CFG_BUTTON: button_q <= cfg_data_i;
        default: begin
          // Writes to unknown indexes are dropped.
        end
      endcase
    end
  end

  assign cfg.analog = analog_q;
  assign cfg.button = button_q;

  // Stage links.
  gbsr_pkg::sample_t  in_data, s1_data, s2_data, out_data;
  gbsr_pkg::squares_t s2_sq;
  logic               s1_valid, s1_ready, s2_valid, s2_ready;

  assign in_data.now = buttons_now_i;
  assign in_data.bef = buttons_before_i;
  assign in_data.lx  = left_x_in_i;
  assign in_data.ly  = left_y_in_i;
  assign in_data.rx  = right_x_in_i;
  assign in_data.ry  = right_y_in_i;

  // Stage 1: button options and axis orientation.
  gbsr_btn u_btn (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .data_i  (in_data),
    .valid_o (s1_valid),
    .ready_i (s1_ready),
    .data_o  (s1_data)
  );

  // Stage 2: squared stick components.
  gbsr_sq u_sq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .data_i  (s1_data),
    .valid_o (s2_valid),
    .ready_i (s2_ready),
    .data_o  (s2_data),
    .sq_o    (s2_sq)
  );

  // Stage 3: dominant stick, assignment, d-pad and clearing.
  gbsr_sel u_sel (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (s2_valid),
    .ready_o (s2_ready),
    .data_i  (s2_data),
    .sq_i    (s2_sq),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_data)
  );

  assign buttons_now_out_o    = out_data.now;
  assign buttons_before_out_o = out_data.bef;
  assign left_x_out_o         = out_data.lx;
  assign left_y_out_o         = out_data.ly;
  assign right_x_out_o        = out_data.rx;
  assign right_y_out_o        = out_data.ry;

endmodule

/* dv/gamepad_button_stick_remapper_tb.sv */
// ----------------------------------------------------------------------------
// gamepad_button_stick_remapper_tb
// Self-checking testbench for the pad sample remapper. Samples are sent on a
// valid/ready channel while the result channel stalls on its own pattern.
// Each accepted sample is run through a predictor here and the result is
// compared field by field. Both option registers are swept through directed
// and random settings, which are only changed while the pipeline is empty.
// ----------------------------------------------------------------------------
module gamepad_button_stick_remapper_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Register indexes that the block has no register behind.
  localparam logic [1:0] CFG_SPARE_A = 2'd2;
  localparam logic [1:0] CFG_SPARE_B = 2'd3;

  // Button option bits.
  localparam logic [8:0] BOPT_DPAD_FACE  = 9'h001;
  localparam logic [8:0] BOPT_FACE_DPAD  = 9'h002;
  localparam logic [8:0] BOPT_TURN_RIGHT = 9'h004;
  localparam logic [8:0] BOPT_TURN_LEFT  = 9'h008;
  localparam logic [8:0] BOPT_NO_SHLDR   = 9'h010;
  localparam logic [8:0] BOPT_SLSR_LR    = 9'h020;
  localparam logic [8:0] BOPT_SLSR_Z     = 9'h040;
  localparam logic [8:0] BOPT_MINUS_PLUS = 9'h080;
  localparam logic [8:0] BOPT_PLUS_MINUS = 9'h100;

  // Analog option bits.
  localparam logic [4:0] AOPT_ORIENT = 5'h01;
  localparam logic [4:0] AOPT_LEFT   = 5'h02;
  localparam logic [4:0] AOPT_RIGHT  = 5'h04;
  localparam logic [4:0] AOPT_DPAD   = 5'h08;
  localparam logic [4:0] AOPT_CLEAR  = 5'h10;
  localparam logic [4:0] AOPT_BOTH   = AOPT_LEFT | AOPT_RIGHT;

  // Cycles without any transaction on any channel before the run is abandoned.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 40;

  // One pad sample, in or out.
  typedef struct packed {
    logic [31:0]        now;
    logic [31:0]        prev;
    logic signed [15:0] lx;
    logic signed [15:0] ly;
    logic signed [15:0] rx;
    logic signed [15:0] ry;
  } pad_t;

  // A set bit in src moves to dst. Empty entries never fire.
  typedef struct packed {
    logic [31:0] src;
    logic [31:0] dst;
  } bit_move_t;

  typedef bit_move_t [7:0] move_list_t;

  localparam bit_move_t NO_MOVE = '{src: 32'h0, dst: 32'h0};

  localparam move_list_t DPAD_TO_FACE = '{
    '{gbsr_pkg::B_RIGHT, gbsr_pkg::B_A}, '{gbsr_pkg::B_DOWN, gbsr_pkg::B_B},
    '{gbsr_pkg::B_UP, gbsr_pkg::B_X}, '{gbsr_pkg::B_LEFT, gbsr_pkg::B_Y},
    NO_MOVE, NO_MOVE, NO_MOVE, NO_MOVE};
  localparam move_list_t FACE_TO_DPAD = '{
    '{gbsr_pkg::B_A, gbsr_pkg::B_RIGHT}, '{gbsr_pkg::B_B, gbsr_pkg::B_DOWN},
    '{gbsr_pkg::B_X, gbsr_pkg::B_UP}, '{gbsr_pkg::B_Y, gbsr_pkg::B_LEFT},
    NO_MOVE, NO_MOVE, NO_MOVE, NO_MOVE};
  localparam move_list_t TURN_RIGHT = '{
    '{gbsr_pkg::B_X, gbsr_pkg::B_A}, '{gbsr_pkg::B_A, gbsr_pkg::B_B},
    '{gbsr_pkg::B_Y, gbsr_pkg::B_X}, '{gbsr_pkg::B_B, gbsr_pkg::B_Y},
    '{gbsr_pkg::B_UP, gbsr_pkg::B_RIGHT}, '{gbsr_pkg::B_RIGHT, gbsr_pkg::B_DOWN},
    '{gbsr_pkg::B_DOWN, gbsr_pkg::B_LEFT}, '{gbsr_pkg::B_LEFT, gbsr_pkg::B_UP}};
  localparam move_list_t TURN_LEFT = '{
    '{gbsr_pkg::B_A, gbsr_pkg::B_X}, '{gbsr_pkg::B_B, gbsr_pkg::B_A},
    '{gbsr_pkg::B_X, gbsr_pkg::B_Y}, '{gbsr_pkg::B_Y, gbsr_pkg::B_B},
    '{gbsr_pkg::B_UP, gbsr_pkg::B_LEFT}, '{gbsr_pkg::B_RIGHT, gbsr_pkg::B_UP},
    '{gbsr_pkg::B_DOWN, gbsr_pkg::B_RIGHT}, '{gbsr_pkg::B_LEFT, gbsr_pkg::B_DOWN}};
  localparam move_list_t SLSR_TO_LR = '{
    '{gbsr_pkg::B_ANYSL, gbsr_pkg::B_L}, '{gbsr_pkg::B_ANYSR, gbsr_pkg::B_R},
    NO_MOVE, NO_MOVE, NO_MOVE, NO_MOVE, NO_MOVE, NO_MOVE};
  localparam move_list_t SLSR_TO_Z = '{
    '{gbsr_pkg::B_ANYSL, gbsr_pkg::B_ZL}, '{gbsr_pkg::B_ANYSR, gbsr_pkg::B_ZR},
    NO_MOVE, NO_MOVE, NO_MOVE, NO_MOVE, NO_MOVE, NO_MOVE};
  localparam move_list_t MINUS_TO_PLUS = '{
    '{gbsr_pkg::B_MINUS, gbsr_pkg::B_PLUS},
    NO_MOVE, NO_MOVE, NO_MOVE, NO_MOVE, NO_MOVE, NO_MOVE, NO_MOVE};
  localparam move_list_t PLUS_TO_MINUS = '{
    '{gbsr_pkg::B_PLUS, gbsr_pkg::B_MINUS},
    NO_MOVE, NO_MOVE, NO_MOVE, NO_MOVE, NO_MOVE, NO_MOVE, NO_MOVE};
  localparam move_list_t ORIENT_DIRS = '{
    '{gbsr_pkg::B_RLEFT, gbsr_pkg::B_RUP}, '{gbsr_pkg::B_RRIGHT, gbsr_pkg::B_RDOWN},
    '{gbsr_pkg::B_RUP, gbsr_pkg::B_RRIGHT}, '{gbsr_pkg::B_RDOWN, gbsr_pkg::B_RLEFT},
    '{gbsr_pkg::B_LLEFT, gbsr_pkg::B_LDOWN}, '{gbsr_pkg::B_LRIGHT, gbsr_pkg::B_LUP},
    '{gbsr_pkg::B_LUP, gbsr_pkg::B_LLEFT}, '{gbsr_pkg::B_LDOWN, gbsr_pkg::B_LRIGHT}};
  localparam move_list_t RIGHT_TO_LEFT = '{
    '{gbsr_pkg::B_RLEFT, gbsr_pkg::B_LLEFT}, '{gbsr_pkg::B_RRIGHT, gbsr_pkg::B_LRIGHT},
    '{gbsr_pkg::B_RUP, gbsr_pkg::B_LUP}, '{gbsr_pkg::B_RDOWN, gbsr_pkg::B_LDOWN},
    '{gbsr_pkg::B_SR, gbsr_pkg::B_SL}, NO_MOVE, NO_MOVE, NO_MOVE};
  localparam move_list_t LEFT_TO_RIGHT = '{
    '{gbsr_pkg::B_LLEFT, gbsr_pkg::B_RLEFT}, '{gbsr_pkg::B_LRIGHT, gbsr_pkg::B_RRIGHT},
    '{gbsr_pkg::B_LUP, gbsr_pkg::B_RUP}, '{gbsr_pkg::B_LDOWN, gbsr_pkg::B_RDOWN},
    '{gbsr_pkg::B_SL, gbsr_pkg::B_SR}, NO_MOVE, NO_MOVE, NO_MOVE};
  localparam move_list_t STICKS_TO_DPAD = '{
    '{gbsr_pkg::B_RLEFT, gbsr_pkg::B_LEFT}, '{gbsr_pkg::B_RRIGHT, gbsr_pkg::B_RIGHT},
    '{gbsr_pkg::B_RUP, gbsr_pkg::B_UP}, '{gbsr_pkg::B_RDOWN, gbsr_pkg::B_DOWN},
    '{gbsr_pkg::B_LLEFT, gbsr_pkg::B_LEFT}, '{gbsr_pkg::B_LRIGHT, gbsr_pkg::B_RIGHT},
    '{gbsr_pkg::B_LUP, gbsr_pkg::B_UP}, '{gbsr_pkg::B_LDOWN, gbsr_pkg::B_DOWN}};

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i;
  logic [8:0]         cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [31:0]        buttons_now_i;
  logic [31:0]        buttons_before_i;
  logic signed [15:0] left_x_in_i;
  logic signed [15:0] left_y_in_i;
  logic signed [15:0] right_x_in_i;
  logic signed [15:0] right_y_in_i;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [31:0]        buttons_now_out_o;
  logic [31:0]        buttons_before_out_o;
  logic signed [15:0] left_x_out_o;
  logic signed [15:0] left_y_out_o;
  logic signed [15:0] right_x_out_o;
  logic signed [15:0] right_y_out_o;

  // Mirror of the option registers, as written through the cfg channel.
  logic [4:0] analog_opts = '0;
  logic [8:0] button_opts = '0;

  // Predicted results, oldest first.
  pad_t expected_pads[$];

  int mismatch_count = 0;
  int result_count   = 0;
  int idle_cycles    = 0;

  // Traffic shaping: the sender runs in bursts with gaps when sender_gaps is
  // set, and the receiver stalls on its own rhythm unless rx_free is set.
  bit sender_gaps = 1'b1;
  bit rx_free     = 1'b0;
  int burst_left  = 0;
  bit rx_phase    = 1'b1;
  int rx_hold     = 0;

  always #1 clk_i = ~clk_i;

  gamepad_button_stick_remapper dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .buttons_now_i       (buttons_now_i),
    .buttons_before_i    (buttons_before_i),
    .left_x_in_i         (left_x_in_i),
    .left_y_in_i         (left_y_in_i),
    .right_x_in_i        (right_x_in_i),
    .right_y_in_i        (right_y_in_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .buttons_now_out_o   (buttons_now_out_o),
    .buttons_before_out_o(buttons_before_out_o),
    .left_x_out_o        (left_x_out_o),
    .left_y_out_o        (left_y_out_o),
    .right_x_out_o       (right_x_out_o),
    .right_y_out_o       (right_y_out_o)
  );

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  function automatic pad_t make_pad(input logic [31:0] now, input logic [31:0] prev,
                                    input logic signed [15:0] lx,
                                    input logic signed [15:0] ly,
                                    input logic signed [15:0] rx,
                                    input logic signed [15:0] ry);
    pad_t p;
    p.now  = now;
    p.prev = prev;
    p.lx   = lx;
    p.ly   = ly;
    p.rx   = rx;
    p.ry   = ry;
    return p;
  endfunction

  // Every entry is tested against the same input word, so one entry can never
  // feed another within a stage.
  function automatic logic [31:0] move_bits(input logic [31:0] v, input move_list_t tbl);
    logic [31:0] cleared;
    logic [31:0] raised;
    cleared = '0;
    raised  = '0;
    foreach (tbl[i]) begin
      if ((v & tbl[i].src) != 32'h0) begin
        cleared |= tbl[i].src;
        raised  |= tbl[i].dst;
      end
    end
    return (v & ~cleared) | raised;
  endfunction

  // The current and previous vectors go through each stage independently.
  function automatic void move_both(inout pad_t p, input move_list_t tbl);
    p.now  = move_bits(p.now, tbl);
    p.prev = move_bits(p.prev, tbl);
  endfunction

  // Negation with the single overflow case clamped to the positive limit.
  function automatic logic signed [15:0] neg_clamp(input logic signed [15:0] v);
    int n;
    n = -int'(v);
    if (n > 32767) n = 32767;
    return n[15:0];
  endfunction

  function automatic pad_t remap_pad(input pad_t p);
    pad_t               q;
    logic signed [15:0] hx;
    logic signed [15:0] hy;
    longint             left_len;
    longint             right_len;
    q = p;

    // Button stages, in their fixed order. Right rotation wins over left.
    if ((button_opts & BOPT_DPAD_FACE) != 0) move_both(q, DPAD_TO_FACE);
    if ((button_opts & BOPT_FACE_DPAD) != 0) move_both(q, FACE_TO_DPAD);
    if ((button_opts & BOPT_TURN_RIGHT) != 0) move_both(q, TURN_RIGHT);
    else if ((button_opts & BOPT_TURN_LEFT) != 0) move_both(q, TURN_LEFT);
    if ((button_opts & BOPT_NO_SHLDR) != 0) begin
      q.now  &= ~gbsr_pkg::SHOULDERS;
      q.prev &= ~gbsr_pkg::SHOULDERS;
    end
    if ((button_opts & BOPT_SLSR_LR) != 0) move_both(q, SLSR_TO_LR);
    if ((button_opts & BOPT_SLSR_Z) != 0) move_both(q, SLSR_TO_Z);
    if ((button_opts & BOPT_MINUS_PLUS) != 0) move_both(q, MINUS_TO_PLUS);
    if ((button_opts & BOPT_PLUS_MINUS) != 0) move_both(q, PLUS_TO_MINUS);

    // Quarter turn: left (x,y) -> (-y,x), right (x,y) -> (y,-x).
    if ((analog_opts & AOPT_ORIENT) != 0) begin
      hx   = neg_clamp(q.ly);
      hy   = q.lx;
      q.lx = hx;
      q.ly = hy;
      hx   = q.ry;
      hy   = neg_clamp(q.rx);
      q.rx = hx;
      q.ry = hy;
      move_both(q, ORIENT_DIRS);
    end

    // The longer stick wins; the left one keeps a tie.
    left_len  = longint'(q.lx) * longint'(q.lx) + longint'(q.ly) * longint'(q.ly);
    right_len = longint'(q.rx) * longint'(q.rx) + longint'(q.ry) * longint'(q.ry);
    if (right_len > left_len) begin
      hx = q.rx;
      hy = q.ry;
    end else begin
      hx = q.lx;
      hy = q.ly;
    end
    if ((analog_opts & AOPT_BOTH) == AOPT_BOTH) begin
      q.lx = hx;
      q.ly = hy;
      q.rx = hx;
      q.ry = hy;
    end else if ((analog_opts & AOPT_LEFT) != 0) begin
      q.lx = hx;
      q.ly = hy;
      q.rx = '0;
      q.ry = '0;
      move_both(q, RIGHT_TO_LEFT);
    end else if ((analog_opts & AOPT_RIGHT) != 0) begin
      q.lx = '0;
      q.ly = '0;
      q.rx = hx;
      q.ry = hy;
      move_both(q, LEFT_TO_RIGHT);
    end

    if ((analog_opts & AOPT_DPAD) != 0) move_both(q, STICKS_TO_DPAD);

    // Clearing drops the stick directions but leaves the other button bits alone.
    if ((analog_opts & AOPT_CLEAR) != 0) begin
      q.lx = '0;
      q.ly = '0;
      q.rx = '0;
      q.ry = '0;
      q.now  &= ~gbsr_pkg::STICK_DIRS;
      q.prev &= ~gbsr_pkg::STICK_DIRS;
    end
    return q;
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("mismatch at result %0d, %s: got %h, expected %h",
               result_count, what, got, want);
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // All channels are observed at the rising edge. The inputs were settled at
  // the falling edge before, and the block's outputs still hold the values of
  // the cycle that is ending, so nothing here depends on event ordering.
  always @(posedge clk_i) begin : monitor
    pad_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        expected_pads.push_back(remap_pad(make_pad(buttons_now_i, buttons_before_i,
                                                   left_x_in_i, left_y_in_i,
                                                   right_x_in_i, right_y_in_i)));
      if (out_valid_o && out_ready_i) begin
        if (expected_pads.size() == 0) begin
          report_mismatch("result with nothing outstanding", buttons_now_out_o, '0);
        end else begin
          want = expected_pads.pop_front();
          check_field("buttons_now", buttons_now_out_o, want.now);
          check_field("buttons_before", buttons_before_out_o, want.prev);
          check_field("left_x", 32'(left_x_out_o), 32'(want.lx));
          check_field("left_y", 32'(left_y_out_o), 32'(want.ly));
          check_field("right_x", 32'(right_x_out_o), 32'(want.rx));
          check_field("right_y", 32'(right_y_out_o), 32'(want.ry));
        end
        result_count++;
      end
      // Unknown indexes and data bits above a register's width are dropped.
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          gbsr_pkg::CFG_ANALOG: analog_opts = cfg_data_i[4:0];
          gbsr_pkg::CFG_BUTTON: button_opts = cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Any transaction on any channel counts as progress.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side back-pressure: alternating ready and stall runs of random
  // length, so stalls land on every stage of the pipeline.
  always @(negedge clk_i) begin
    if (rx_hold != 0) begin
      rx_hold--;
    end else begin
      rx_phase = !rx_phase;
      rx_hold  = rx_phase ? $urandom_range(0, 9) : $urandom_range(0, 4);
    end
    out_ready_i <= rx_free || rx_phase;
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Presents one sample and returns at the edge where the transaction takes
  // place. Valid is left high so that a following sample goes out back to
  // back; gaps and the drain lower it.
  task automatic send_pad(input pad_t p);
    int gap;
    if (sender_gaps && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
      end
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left != 0) burst_left--;
    @(negedge clk_i);
    in_valid_i       <= 1'b1;
    buttons_now_i    <= p.now;
    buttons_before_i <= p.prev;
    left_x_in_i      <= p.lx;
    left_y_in_i      <= p.ly;
    right_x_in_i     <= p.rx;
    right_y_in_i     <= p.ry;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [8:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Stops sending and waits for every outstanding result, then lets the clock
  // run on so that nothing stray is still on its way through the pipeline.
  task automatic drain;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_pads.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Option registers are only changed with the pipeline empty.
  task automatic set_options(input logic [8:0] analog, input logic [8:0] button);
    drain();
    write_reg(gbsr_pkg::CFG_ANALOG, analog);
    write_reg(gbsr_pkg::CFG_BUTTON, button);
  endtask

  // --------------------------------------------------------------------------
  // Random sample generation
  // --------------------------------------------------------------------------

  // Dense vectors saturate every remap stage, so sparse ones are favoured.
  function automatic logic [31:0] random_buttons();
    case ($urandom_range(0, 7))
      0, 1:    return $urandom();
      2, 3:    return $urandom() & $urandom();
      4:       return $urandom() & $urandom() & $urandom();
      5:       return 32'h1 << $urandom_range(0, 31);
      6:       return $urandom() & 32'h0FFF_FFFF;
      default: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
    endcase
  endfunction

  function automatic logic signed [15:0] random_axis();
    case ($urandom_range(0, 9))
      0:       return gbsr_pkg::STICK_MIN;
      1:       return gbsr_pkg::STICK_MAX;
      2:       return 16'sh0000;
      3:       return -16'sh0001;
      4, 5:    return 16'($urandom_range(0, 400)) - 16'sd200;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic pad_t random_pad();
    pad_t p;
    p.now  = random_buttons();
    p.prev = ($urandom_range(0, 3) == 0) ? p.now : random_buttons();
    p.lx   = random_axis();
    p.ly   = random_axis();
    p.rx   = random_axis();
    p.ry   = random_axis();
    // Swapped axes give two sticks of exactly the same length.
    if ($urandom_range(0, 7) == 0) begin
      p.rx = p.ly;
      p.ry = p.lx;
    end
    return p;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // With both registers at their reset value every sample passes unchanged.
  task automatic test_passthrough;
    send_pad(make_pad('0, '0, 16'sh0, 16'sh0, 16'sh0, 16'sh0));
    send_pad(make_pad('1, '1, gbsr_pkg::STICK_MIN, gbsr_pkg::STICK_MAX,
                      gbsr_pkg::STICK_MAX, gbsr_pkg::STICK_MIN));
    send_pad(make_pad(32'hA5A5_5A5A, 32'h5A5A_A5A5, -16'sh1, 16'sh1,
                      16'sh4000, -16'sh4000));
  endtask

  // Each button option on its own, then both rotations together, where only
  // the right rotation should take effect. The two vectors are chosen so that
  // some but not all sources of every stage are present.
  task automatic test_button_stages;
    logic [8:0] opt;
    for (int i = 0; i < 9; i++) begin
      opt = 9'h001 << i;
      set_options('0, opt);
      send_pad(make_pad(32'h05A0_5C95, 32'hFA5F_A36A, 16'sh0123, -16'sh0123,
                        gbsr_pkg::STICK_MIN, gbsr_pkg::STICK_MAX));
    end
    set_options('0, BOPT_TURN_RIGHT | BOPT_TURN_LEFT);
    send_pad(make_pad(32'h0000_A005, 32'h0000_500A, 16'sh0, 16'sh0, 16'sh0, 16'sh0));
  endtask

  task automatic test_analog_stages;
    // Quarter turn with the most negative value on the axes that get negated.
    set_options(9'(AOPT_ORIENT), '0);
    send_pad(make_pad(32'h00A5_0000, 32'h005A_0000, 16'sh0064, gbsr_pkg::STICK_MIN,
                      gbsr_pkg::STICK_MIN, -16'sh00C8));
    // Right stick is longer and moves to the left, with its buttons.
    set_options(9'(AOPT_LEFT), '0);
    send_pad(make_pad(32'h00F0_0020, 32'h0030_0030, 16'sh000A, 16'sh000A,
                      gbsr_pkg::STICK_MIN, 16'sh0005));
    // Left stick is longer and moves to the right, with its buttons.
    set_options(9'(AOPT_RIGHT), '0);
    send_pad(make_pad(32'h000F_0010, 32'h00FF_0030, gbsr_pkg::STICK_MIN,
                      gbsr_pkg::STICK_MIN, gbsr_pkg::STICK_MAX, gbsr_pkg::STICK_MAX));
    // Both sides take the longer stick; on equal lengths the left one wins.
    set_options(9'(AOPT_BOTH), '0);
    send_pad(make_pad(32'h00FF_0030, 32'h00FF_0030, 16'sh0001, 16'sh0002,
                      -16'sh0300, 16'sh0007));
    send_pad(make_pad('0, '0, 16'sh0003, 16'sh0004, -16'sh0004, 16'sh0003));
    send_pad(make_pad('0, '0, gbsr_pkg::STICK_MIN, 16'sh0, 16'sh0,
                      gbsr_pkg::STICK_MIN));
    // Stick directions onto the d-pad.
    set_options(9'(AOPT_DPAD), '0);
    send_pad(make_pad(32'h00FF_0000, 32'h0081_F000, 16'sh0010, 16'sh0020,
                      16'sh0030, 16'sh0040));
    // Clearing, with different current and previous vectors.
    set_options(9'(AOPT_CLEAR), '0);
    send_pad(make_pad(32'h00FF_0030, 32'h0F0F_0F0F, gbsr_pkg::STICK_MAX,
                      gbsr_pkg::STICK_MIN, -16'sh0001, 16'sh0001));
    // Every analog stage at once, on top of every button stage.
    set_options(9'h01F, 9'h1FF);
    send_pad(make_pad(32'h0FFF_FFFF, 32'h00A5_5A0F, gbsr_pkg::STICK_MIN, 16'sh0100,
                      16'sh0200, gbsr_pkg::STICK_MIN));
  endtask

  // Data bits above the analog register's width, and writes to indexes that
  // have no register, must leave the settings as they were.
  task automatic test_register_corners;
    set_options(9'h1E3, '0);
    write_reg(CFG_SPARE_A, 9'h1FF);
    write_reg(CFG_SPARE_B, 9'h1FF);
    send_pad(make_pad(32'h00C3_0C3C, 32'h003C_C3C3, 16'sh1234, -16'sh4321,
                      16'sh7000, -16'sh6000));
  endtask

  // Random samples under a sequence of settings, the extremes first, with
  // the traffic shaping changed from phase to phase.
  task automatic test_random_traffic;
    logic [8:0] analog;
    logic [8:0] button;
    for (int phase = 0; phase < 10; phase++) begin
      if (phase == 0) begin
        analog = '0;
        button = '0;
      end else if (phase == 1) begin
        analog = 9'h1FF;
        button = 9'h1FF;
      end else if (phase == 2) begin
        analog = 9'(AOPT_BOTH | AOPT_ORIENT);
        button = BOPT_SLSR_LR | BOPT_SLSR_Z;
      end else begin
        analog = 9'($urandom_range(0, 511));
        button = 9'($urandom_range(0, 511));
      end
      set_options(analog, button);
      if (phase % 2 == 1) write_reg(CFG_SPARE_A, 9'($urandom()));
      sender_gaps = (phase % 3 != 0);
      rx_free     = (phase % 3 == 0);
      repeat (55) send_pad(random_pad());
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    rst_ni           = 1'b0;
    cfg_valid_i      = 1'b0;
    cfg_index_i      = gbsr_pkg::CFG_ANALOG;
    cfg_data_i       = '0;
    in_valid_i       = 1'b0;
    buttons_now_i    = '0;
    buttons_before_i = '0;
    left_x_in_i      = '0;
    left_y_in_i      = '0;
    right_x_in_i     = '0;
    right_y_in_i     = '0;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_passthrough();
    test_button_stages();
    test_analog_stages();
    test_register_corners();
    test_random_traffic();
    drain();

    if (mismatch_count == 0 && expected_pads.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
